@@ rtl/abas_pkg.sv @@
// ----------------------------------------------------------------------------
// abas_pkg
// Shared sizes, codes and the one's-complement add for the alternating-bit
// ARQ sender.
// ----------------------------------------------------------------------------
package abas_pkg;

  localparam int DATA_WORDS = 10;
  localparam int WORD_W     = 16;
  localparam int VERDICT_W  = 2;
  localparam int IDX_W      = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int CNT_W      = $clog2(DATA_WORDS + 1);
  localparam int POS_W      = $clog2(DATA_WORDS + 2);

  localparam logic [WORD_W-1:0] ONES = '1;

  localparam logic REQ_MSG = 1'b0;
  localparam logic REQ_ACK = 1'b1;

  localparam logic KIND_PACKET  = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [VERDICT_W-1:0] V_ACKED    = 2'd0;
  localparam logic [VERDICT_W-1:0] V_CORRUPT  = 2'd1;
  localparam logic [VERDICT_W-1:0] V_OLD      = 2'd2;
  localparam logic [VERDICT_W-1:0] V_REJECTED = 2'd3;

  // end-around carry add
  function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, t[WORD_W]};
  endfunction

endpackage

@@ rtl/abas_if.sv @@
// ----------------------------------------------------------------------------
// abas_in_if / abas_out_if
// Valid/ready channels of the alternating-bit ARQ sender.
// ----------------------------------------------------------------------------
interface abas_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [abas_pkg::WORD_W-1:0]  word_in;
  logic                         word_last;

  modport source (output valid, req_type, word_in, word_last, input ready);
  modport sink (input valid, req_type, word_in, word_last, output ready);
endinterface

interface abas_out_if;
  logic                            valid;
  logic                            ready;
  logic                            result_kind;
  logic [abas_pkg::WORD_W-1:0]     word_out;
  logic                            packet_last;
  logic [abas_pkg::VERDICT_W-1:0]  verdict;

  modport source (output valid, result_kind, word_out, packet_last, verdict, input ready);
  modport sink (input valid, result_kind, word_out, packet_last, verdict, output ready);
endinterface

@@ rtl/alternating_bit_arq_sender.sv @@
// ----------------------------------------------------------------------------
// alternating_bit_arq_sender
// Stop-and-wait sender with an alternating sequence bit: buffers a message,
// sends it as a checksummed packet and checks the returning acknowledgement.
// ----------------------------------------------------------------------------
// Input words are taken one per cycle while the sender is idle and the output
// register is free. Message words fill a DATA_WORDS-entry store; the last one
// starts a packet of DATA_WORDS + 2 words (sequence word, data words zero
// padded past the message length, inverted one's-complement checksum). Each
// packet word goes through a store read (S_READ) and then the output load
// (S_EMIT) with one pass through the shared end-around-carry adder; an output
// stall holds S_EMIT, and no input is taken while a packet is sent. Ack words
// run through the same adder; the ack's last word gives a verdict item,
// followed by a full retransmission when the ack is corrupted or carries the
// old sequence bit. Message words arriving while an ack is awaited each get a
// reject verdict. Ack words arriving while no ack is awaited are dropped.
// ----------------------------------------------------------------------------
module alternating_bit_arq_sender (
  input logic        clk,
  input logic        rst,
  abas_in_if.sink    in_ch,
  abas_out_if.source out_ch
);
  import abas_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(DATA_WORDS + 1);
  localparam logic [CNT_W-1:0] FULL     = CNT_W'(DATA_WORDS);

  logic [1:0]           state;
  logic                 seq_bit;
  logic                 awaiting_ack;
  logic [CNT_W-1:0]     fill;
  logic [CNT_W-1:0]     msg_len;
  logic [POS_W-1:0]     pos;
  logic [WORD_W-1:0]    acc;
  logic                 ack_first;
  logic                 seq_ok;

  logic [WORD_W-1:0]    store [DATA_WORDS];
  logic [WORD_W-1:0]    rd_data;

  logic                 out_valid;
  logic                 out_kind;
  logic [WORD_W-1:0]    out_word;
  logic                 out_last;
  logic [VERDICT_W-1:0] out_verdict;

  logic                 out_free;
  logic                 in_fire;
  logic                 store_wr;
  logic [CNT_W-1:0]     fill_inc;
  logic [POS_W-1:0]     pos_m1;
  logic [IDX_W-1:0]     rd_addr;
  logic [WORD_W-1:0]    emit_word;
  logic [WORD_W-1:0]    sum_b;
  logic [WORD_W-1:0]    sum_new;
  logic                 match_now;

  assign out_free  = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && out_free;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign store_wr  = in_fire && (in_ch.req_type == REQ_MSG) && !awaiting_ack && (fill < FULL);
  assign fill_inc  = (fill < FULL) ? fill + 1'b1 : fill;
  assign pos_m1    = pos - 1'b1;
  assign rd_addr   = pos_m1[IDX_W-1:0];
  assign match_now = ack_first ? (in_ch.word_in == {{(WORD_W-1){1'b0}}, seq_bit}) : seq_ok;

  always_comb begin
    if (pos == '0) begin
      emit_word = {{(WORD_W-1){1'b0}}, seq_bit};
    end else if (pos == LAST_POS) begin
      emit_word = ~acc;
    end else if (pos <= POS_W'(msg_len)) begin
      emit_word = rd_data;
    end else begin
      emit_word = '0;
    end
  end

  assign sum_b   = (state == S_EMIT) ? emit_word : in_ch.word_in;
  assign sum_new = oc_add(acc, sum_b);

  // message store
  always_ff @(posedge clk) begin
    if (store_wr) begin
      store[fill[IDX_W-1:0]] <= in_ch.word_in;
    end
    if (state == S_READ && pos != '0 && pos != LAST_POS) begin
      rd_data <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      seq_bit      <= 1'b0;
      awaiting_ack <= 1'b0;
      fill         <= '0;
      msg_len      <= '0;
      pos          <= '0;
      acc          <= '0;
      ack_first    <= 1'b1;
      seq_ok       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (in_ch.req_type == REQ_MSG) begin
              if (awaiting_ack) begin
                out_valid   <= 1'b1;
                out_kind    <= KIND_VERDICT;
                out_word    <= '0;
                out_last    <= 1'b0;
                out_verdict <= V_REJECTED;
              end else begin
                fill <= fill_inc;
                if (in_ch.word_last) begin
                  msg_len      <= fill_inc;
                  fill         <= '0;
                  awaiting_ack <= 1'b1;
                  pos          <= '0;
                  acc          <= '0;
                  state        <= S_READ;
                end
              end
            end else if (awaiting_ack) begin
              ack_first <= 1'b0;
              seq_ok    <= match_now;
              acc       <= sum_new;
              if (in_ch.word_last) begin
                ack_first <= 1'b1;
                seq_ok    <= 1'b0;
                acc       <= '0;
                pos       <= '0;
                out_valid <= 1'b1;
                out_kind  <= KIND_VERDICT;
                out_word  <= '0;
                out_last  <= 1'b0;
                if (sum_new != ONES) begin
                  out_verdict <= V_CORRUPT;
                  state       <= S_READ;
                end else if (!match_now) begin
                  out_verdict <= V_OLD;
                  state       <= S_READ;
                end else begin
                  out_verdict  <= V_ACKED;
                  seq_bit      <= ~seq_bit;
                  awaiting_ack <= 1'b0;
                end
              end
            end
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_kind    <= KIND_PACKET;
            out_word    <= emit_word;
            out_last    <= (pos == LAST_POS);
            out_verdict <= V_ACKED;
            if (pos == LAST_POS) begin
              pos   <= '0;
              acc   <= '0;
              state <= S_IDLE;
            end else begin
              pos   <= pos + 1'b1;
              acc   <= sum_new;
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.result_kind = out_kind;
  assign out_ch.word_out    = out_word;
  assign out_ch.packet_last = out_last;
  assign out_ch.verdict     = out_verdict;

`ifndef SYNTHESIS
  a_last_is_packet: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.packet_last |-> out_ch.result_kind == KIND_PACKET)
    else $error("packet_last on a verdict item");

  a_checksum_ends_packet: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT && out_free && pos == LAST_POS
      |=> out_ch.valid && out_ch.packet_last && awaiting_ack)
    else $error("checksum word not delivered at end of packet");

  a_busy_only_when_awaiting: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> awaiting_ack)
    else $error("packet in flight without awaiting ack");

  a_msg_len_range: assert property (@(posedge clk) disable iff (rst)
    msg_len <= FULL && fill <= FULL)
    else $error("message length beyond store depth");
`endif

endmodule
